>>> hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and codes of the character stream tokenizer
// Token kinds, error codes, the request and result records and the byte
// classification helpers used by the scanner and the port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

	localparam int KindW = 5;
	localparam int ErrW  = 3;
	localparam int ByteW = 8;

	localparam logic [KindW-1:0] KIND_EOF        = 5'd0;
	localparam logic [KindW-1:0] KIND_NUM        = 5'd1;
	localparam logic [KindW-1:0] KIND_STR        = 5'd2;
	localparam logic [KindW-1:0] KIND_IDENT      = 5'd3;
	localparam logic [KindW-1:0] KIND_LPAREN     = 5'd4;
	localparam logic [KindW-1:0] KIND_RPAREN     = 5'd5;
	localparam logic [KindW-1:0] KIND_LBRACE     = 5'd6;
	localparam logic [KindW-1:0] KIND_RBRACE     = 5'd7;
	localparam logic [KindW-1:0] KIND_SEMI       = 5'd8;
	localparam logic [KindW-1:0] KIND_EQUAL      = 5'd9;
	localparam logic [KindW-1:0] KIND_GREATER    = 5'd10;
	localparam logic [KindW-1:0] KIND_LESS       = 5'd11;
	localparam logic [KindW-1:0] KIND_PLUS       = 5'd12;
	localparam logic [KindW-1:0] KIND_MINUS      = 5'd13;
	localparam logic [KindW-1:0] KIND_STAR       = 5'd14;
	localparam logic [KindW-1:0] KIND_SLASH      = 5'd15;
	localparam logic [KindW-1:0] KIND_BACKSLASH  = 5'd16;
	localparam logic [KindW-1:0] KIND_COMMA      = 5'd17;
	localparam logic [KindW-1:0] KIND_PIPE       = 5'd18;
	localparam logic [KindW-1:0] KIND_AMP        = 5'd19;
	localparam logic [KindW-1:0] KIND_BANG       = 5'd20;

	localparam logic [ErrW-1:0] ERR_NONE       = 3'd0;
	localparam logic [ErrW-1:0] ERR_UNEXPECTED = 3'd1;
	localparam logic [ErrW-1:0] ERR_POINTS     = 3'd2;
	localparam logic [ErrW-1:0] ERR_OPEN_STR   = 3'd3;
	localparam logic [ErrW-1:0] ERR_EMPTY      = 3'd4;

	localparam logic [ByteW-1:0] CH_BACKSLASH = 8'd92;
	localparam logic [ByteW-1:0] CH_POINT     = 8'd46;
	localparam logic [ByteW-1:0] CH_QUOTE     = 8'd34;

	typedef struct packed {
		logic             take;
		logic [ByteW-1:0] char_code;
		logic             end_of_input;
	} scan_req_t;

	typedef struct packed {
		logic             valid;
		logic [KindW-1:0] token_kind;
		logic [ByteW-1:0] byte_out;
		logic             has_byte;
		logic             starts_token;
		logic [ErrW-1:0]  error_code;
	} scan_res_t;

	function automatic logic is_digit(input logic [ByteW-1:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

	function automatic logic is_letter(input logic [ByteW-1:0] c);
		return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
	endfunction

	function automatic logic is_space(input logic [ByteW-1:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// Returns a hit flag above the punctuation kind.
	function automatic logic [KindW:0] punct_kind(input logic [ByteW-1:0] c);
		logic [KindW:0] r;
		case (c)
			8'd40:   r = {1'b1, KIND_LPAREN};
			8'd41:   r = {1'b1, KIND_RPAREN};
			8'd123:  r = {1'b1, KIND_LBRACE};
			8'd125:  r = {1'b1, KIND_RBRACE};
			8'd59:   r = {1'b1, KIND_SEMI};
			8'd61:   r = {1'b1, KIND_EQUAL};
			8'd62:   r = {1'b1, KIND_GREATER};
			8'd60:   r = {1'b1, KIND_LESS};
			8'd43:   r = {1'b1, KIND_PLUS};
			8'd45:   r = {1'b1, KIND_MINUS};
			8'd42:   r = {1'b1, KIND_STAR};
			8'd47:   r = {1'b1, KIND_SLASH};
			8'd92:   r = {1'b1, KIND_BACKSLASH};
			8'd44:   r = {1'b1, KIND_COMMA};
			8'd124:  r = {1'b1, KIND_PIPE};
			8'd38:   r = {1'b1, KIND_AMP};
			8'd33:   r = {1'b1, KIND_BANG};
			default: r = {1'b0, KIND_EOF};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cst_scan.sv
// ----------------------------------------------------------------------------
// cst_scan: scanning state and per-byte token decision
// Holds the scan mode and flags and works out, for the request offered this
// cycle, the result it gives and the state it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_scan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cst_pkg::scan_req_t req,
	output cst_pkg::scan_res_t      res
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_STR,
		MODE_ESC,
		MODE_HALT
	} mode_t;

	mode_t mode_q, mode_d;
	logic  point_q, point_d;
	logic  seen_q, seen_d;

	logic [7:0] c;
	logic       dig, let_c, spc, pnt, quo, bsl;
	logic [5:0] pk;

	assign c     = req.char_code;
	assign dig   = cst_pkg::is_digit(c);
	assign let_c = cst_pkg::is_letter(c);
	assign spc   = cst_pkg::is_space(c);
	assign pnt   = (c == cst_pkg::CH_POINT);
	assign quo   = (c == cst_pkg::CH_QUOTE);
	assign bsl   = (c == cst_pkg::CH_BACKSLASH);
	assign pk    = cst_pkg::punct_kind(c);

	always_comb begin
		logic opener;
		opener  = 1'b0;
		mode_d  = mode_q;
		point_d = point_q;
		seen_d  = seen_q;
		res     = '0;

		if (mode_q == MODE_HALT) begin
			mode_d = MODE_HALT;
		end else if (req.end_of_input) begin
			if ((mode_q == MODE_STR) || (mode_q == MODE_ESC)) begin
				mode_d         = MODE_HALT;
				res.valid      = 1'b1;
				res.error_code = cst_pkg::ERR_OPEN_STR;
			end else if (!seen_q) begin
				mode_d         = MODE_HALT;
				res.valid      = 1'b1;
				res.error_code = cst_pkg::ERR_EMPTY;
			end else begin
				mode_d           = MODE_IDLE;
				point_d          = 1'b0;
				seen_d           = 1'b0;
				res.valid        = 1'b1;
				res.token_kind   = cst_pkg::KIND_EOF;
				res.starts_token = 1'b1;
			end
		end else begin
			seen_d = 1'b1;
			case (mode_q)
				MODE_NUM: begin
					if (dig || (pnt && !point_q)) begin
						point_d      = point_q | pnt;
						res.valid    = 1'b1;
						res.token_kind = cst_pkg::KIND_NUM;
						res.byte_out = c;
						res.has_byte = 1'b1;
					end else if (pnt) begin
						mode_d         = MODE_HALT;
						res.valid      = 1'b1;
						res.error_code = cst_pkg::ERR_POINTS;
					end else begin
						opener = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (dig || let_c) begin
						res.valid      = 1'b1;
						res.token_kind = cst_pkg::KIND_IDENT;
						res.byte_out   = c;
						res.has_byte   = 1'b1;
					end else begin
						opener = 1'b1;
					end
				end
				MODE_STR: begin
					if (quo) begin
						mode_d = MODE_IDLE;
					end else if (bsl) begin
						mode_d = MODE_ESC;
					end else begin
						res.valid      = 1'b1;
						res.token_kind = cst_pkg::KIND_STR;
						res.byte_out   = c;
						res.has_byte   = 1'b1;
					end
				end
				MODE_ESC: begin
					mode_d         = MODE_STR;
					res.valid      = 1'b1;
					res.token_kind = cst_pkg::KIND_STR;
					res.byte_out   = c;
					res.has_byte   = 1'b1;
				end
				default: begin
					opener = 1'b1;
				end
			endcase

			if (opener) begin
				mode_d = MODE_IDLE;
				if (spc) begin
					mode_d = MODE_IDLE;
				end else if (dig || pnt) begin
					mode_d           = MODE_NUM;
					point_d          = pnt;
					res.valid        = 1'b1;
					res.token_kind   = cst_pkg::KIND_NUM;
					res.byte_out     = c;
					res.has_byte     = 1'b1;
					res.starts_token = 1'b1;
				end else if (quo) begin
					mode_d           = MODE_STR;
					res.valid        = 1'b1;
					res.token_kind   = cst_pkg::KIND_STR;
					res.starts_token = 1'b1;
				end else if (let_c) begin
					mode_d           = MODE_IDENT;
					res.valid        = 1'b1;
					res.token_kind   = cst_pkg::KIND_IDENT;
					res.byte_out     = c;
					res.has_byte     = 1'b1;
					res.starts_token = 1'b1;
				end else if (pk[5]) begin
					res.valid        = 1'b1;
					res.token_kind   = pk[4:0];
					res.byte_out     = c;
					res.has_byte     = 1'b1;
					res.starts_token = 1'b1;
				end else begin
					mode_d         = MODE_HALT;
					res.valid      = 1'b1;
					res.error_code = cst_pkg::ERR_UNEXPECTED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			point_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (req.take) begin
			mode_q  <= mode_d;
			point_q <= point_d;
			seen_q  <= seen_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/char_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top: streaming tokenizer, one byte per request
// Input requests carry a byte in s_tdata, or an end of text with s_tlast.
// Output requests carry token marks and streamed token text.
// ----------------------------------------------------------------------------
// Usage: the source offers one byte per request on the s_ group; s_tlast
// high marks the end of a text and its byte is ignored. Each request gives
// zero or one result on the m_ group: m_tuser holds the token kind, m_tdata
// the token byte, the has_byte and starts_token marks and the error code.
// The result of a request is held in the output register and shown in the
// cycle after the request is taken. Throughput is one request per cycle,
// set by the single output register that sits between the scanner and the
// m_ group; a new request is taken whenever that register is empty or being
// emptied in the same cycle. When the receiver stalls, the output register
// holds its result and s_tready drops until it is taken. After an error
// result the scanner halts and quietly consumes every further request until
// arst_n is asserted. Reset clears the scan state and the output valid flag
// but not the held result; the block is ready once reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_tokenizer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] char_code
	input  wire logic        s_tlast,  // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [7:0] byte_out, [8] has_byte,
	                                   // [9] starts_token, [12:10] error_code
	output logic [4:0]       m_tuser   // [4:0] token_kind
);

	cst_pkg::scan_req_t req;
	cst_pkg::scan_res_t res;
	cst_pkg::scan_res_t res_q;
	logic               m_tvalid_q;

	assign s_tready         = !m_tvalid_q || m_tready;
	assign req.take         = s_tvalid && s_tready;
	assign req.char_code    = s_tdata;
	assign req.end_of_input = s_tlast;

	cst_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= req.take && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && req.take && res.valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.token_kind;
	assign m_tdata  = {3'b000, res_q.error_code, res_q.starts_token, res_q.has_byte,
		res_q.byte_out};

endmodule

`default_nettype wire

>>> hw/rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker: port checks of the character stream tokenizer
// Watches the top level's ports and flags results that break the rules of
// the token stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [4:0]  m_tuser
);

	logic [2:0] err;
	logic       has_b;
	logic       starts;

	assign err    = m_tdata[12:10];
	assign has_b  = m_tdata[8];
	assign starts = m_tdata[9];

	// A stalled result stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The input side is open whenever the output register can take a result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input refused with room at the output");

	// An error result carries no token content.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (err != cst_pkg::ERR_NONE) |->
		(m_tuser == cst_pkg::KIND_EOF) && !has_b && !starts && (m_tdata[7:0] == 8'd0))
		else $error("error result with token content");

	// After an error result is delivered the block gives nothing more.
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (err != cst_pkg::ERR_NONE) |=> !m_tvalid)
		else $error("result after an error");

	// A result without text is a string opener or an end of text token.
	a_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (err == cst_pkg::ERR_NONE) && !has_b |->
		starts && ((m_tuser == cst_pkg::KIND_STR) || (m_tuser == cst_pkg::KIND_EOF)) &&
		(m_tdata[7:0] == 8'd0))
		else $error("textless result is not a token start");

endmodule

bind char_stream_tokenizer_top cst_checker u_cst_checker (.*);

`default_nettype wire
